// ===== rtl/sha_pkg.sv =====
// Shared types and constants for the SHA-256 message hasher.
// Holds the round constants, initial hash values, state enums and the core control struct.
// No dependencies.
package sha_pkg;

  localparam int unsigned BlkWords  = 16;
  localparam int unsigned HashWords = 8;

  localparam logic [7:0]  PadByte   = 8'h80;
  localparam logic [5:0]  LenLimit  = 6'd56;
  localparam logic [3:0]  LenWordHi = 4'd14;
  localparam logic [3:0]  LenWordLo = 4'd15;
  localparam logic [63:0] BlockBits = 64'd512;

  localparam logic [31:0] HashInit [HashWords] = '{
    32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
    32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
  };

  localparam logic [31:0] RoundK [64] = '{
    32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5, 32'h3956C25B,
    32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5, 32'hD807AA98, 32'h12835B01,
    32'h243185BE, 32'h550C7DC3, 32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7,
    32'hC19BF174, 32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
    32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA, 32'h983E5152,
    32'hA831C66D, 32'hB00327C8, 32'hBF597FC7, 32'hC6E00BF3, 32'hD5A79147,
    32'h06CA6351, 32'h14292967, 32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC,
    32'h53380D13, 32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
    32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3, 32'hD192E819,
    32'hD6990624, 32'hF40E3585, 32'h106AA070, 32'h19A4C116, 32'h1E376C08,
    32'h2748774C, 32'h34B0BCB5, 32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F,
    32'h682E6FF3, 32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
    32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
  };

  typedef enum logic [2:0] {
    T_IDLE,
    T_COMP,
    T_PAD,
    T_EMIT_RD,
    T_EMIT_OUT
  } top_state_t;

  typedef enum logic [1:0] {
    C_IDLE,
    C_LOAD,
    C_ROUND,
    C_UPDATE
  } core_state_t;

  typedef enum logic [1:0] {
    K_DATA,
    K_PADX,
    K_FINAL
  } comp_kind_t;

  typedef struct packed {
    logic       start;
    logic       restart;
    logic       dig_re;
    logic [2:0] dig_addr;
  } sha_ctl_t;

endpackage

// ===== rtl/sha_ram.sv =====
// Generic single-write, single-read synchronous RAM with a registered read port.
// No dependencies.
module sha_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AddrW-1:0] waddr,
  input  logic [Width-1:0] wdata,
  input  logic             re,
  input  logic [AddrW-1:0] raddr,
  output logic [Width-1:0] rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/sha_core.sv =====
// SHA-256 compression engine: one round per cycle over the block RAM contents.
// Holds the hash words in a RAM and updates them in place; uses sha_pkg and sha_ram.
module sha_core (
  input  logic              clk,
  input  logic              rst,
  input  sha_pkg::sha_ctl_t ctl,
  output logic              done,
  output logic              blk_re,
  output logic [3:0]        blk_raddr,
  input  logic [31:0]       blk_rdata,
  output logic [31:0]       dig_data
);
  import sha_pkg::*;

  core_state_t cst, cst_next;
  logic [5:0]  step;
  logic        fresh;
  logic [2:0]  hraddr_q;
  logic [31:0] v [8];
  logic [31:0] win [BlkWords];
  logic [31:0] wreg;

  logic        h_we, h_re;
  logic [2:0]  h_waddr, h_raddr;
  logic [31:0] h_wdata, h_rdata, hrd;
  logic [31:0] wt, t1, t2, sched;

  function automatic logic [31:0] ror(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  sha_ram #(.Width(32), .Depth(HashWords)) u_hash_ram (
    .clk  (clk),
    .we   (h_we),
    .waddr(h_waddr),
    .wdata(h_wdata),
    .re   (h_re),
    .raddr(h_raddr),
    .rdata(h_rdata)
  );

  // Until the first compression of a message writes back, the RAM stands for the IV.
  assign hrd      = fresh ? HashInit[hraddr_q] : h_rdata;
  assign dig_data = hrd;
  assign h_wdata  = hrd + v[0];
  assign h_waddr  = step[2:0] - 3'd1;

  assign wt = (step[5:4] == 2'b00) ? blk_rdata : wreg;
  assign t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
            + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundK[step] + wt;
  assign t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
            + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
  // Schedule word for the next round, from the window before this round's word enters.
  assign sched = (ror(win[15], 17) ^ ror(win[15], 19) ^ (win[15] >> 10)) + win[10]
               + (ror(win[2], 7) ^ ror(win[2], 18) ^ (win[2] >> 3)) + win[1];

  always_comb begin
    cst_next  = cst;
    done      = 1'b0;
    h_we      = 1'b0;
    h_re      = 1'b0;
    h_raddr   = step[2:0];
    blk_re    = 1'b0;
    blk_raddr = step[3:0] + 4'd1;
    unique case (cst)
      C_IDLE: begin
        h_re    = ctl.dig_re;
        h_raddr = ctl.dig_addr;
        if (ctl.start) begin
          cst_next = C_LOAD;
        end
      end
      C_LOAD: begin
        h_re = !step[3];
        if (step == 6'd8) begin
          blk_re    = 1'b1;
          blk_raddr = 4'd0;
          cst_next  = C_ROUND;
        end
      end
      C_ROUND: begin
        blk_re = (step < 6'd15);
        if (step == 6'd63) begin
          cst_next = C_UPDATE;
        end
      end
      C_UPDATE: begin
        h_re = !step[3];
        h_we = (step != 6'd0);
        if (step == 6'd8) begin
          done     = 1'b1;
          cst_next = C_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cst   <= C_IDLE;
      step  <= 6'd0;
      fresh <= 1'b1;
    end else begin
      cst  <= cst_next;
      step <= (cst_next != cst) ? 6'd0 : step + 6'd1;
      if (ctl.restart) begin
        fresh <= 1'b1;
      end else if (done) begin
        fresh <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (h_re) begin
      hraddr_q <= h_raddr;
    end
    if (((cst == C_LOAD) || (cst == C_UPDATE)) && (step != 6'd0)) begin
      for (int i = 0; i < 7; i++) begin
        v[i] <= v[i+1];
      end
      v[7] <= hrd;
    end else if (cst == C_ROUND) begin
      v[0] <= t1 + t2;
      v[1] <= v[0];
      v[2] <= v[1];
      v[3] <= v[2];
      v[4] <= v[3] + t1;
      v[5] <= v[4];
      v[6] <= v[5];
      v[7] <= v[6];
      for (int i = 0; i < BlkWords - 1; i++) begin
        win[i] <= win[i+1];
      end
      win[BlkWords-1] <= wt;
      wreg            <= sched;
    end
  end

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    ctl.start |-> (cst == C_IDLE))
    else $error("compression started while the core was busy");

  a_done_after_rounds: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(cst == C_ROUND, 9))
    else $error("write-back finished without a preceding round pass");

endmodule

// ===== rtl/sha256_message_hasher.sv =====
// Top level of the SHA-256 message hasher: byte collection, padding and digest output.
// Uses sha_pkg, sha_ram for the block buffer and sha_core for the compression.
//
//  channel | signals         | payload
//  --------+-----------------+------------------------------------------------
//  in      | s_axis_*        | message byte, byte-valid flag, end of message
//  out     | m_axis_*        | 32-bit digest word, word index, last word
//
// A byte request is taken while idle; the 64th byte of a block starts a compression
// (hash reads, 64 rounds, write-backs), during which no request is taken.
// End of message adds up to 16 padding writes and a compression, twice when the length
// does not fit, then a read and an output per digest word. Reset clears control state only.
// A stalled digest word holds; no new request is taken until the digest is out.
module sha256_message_hasher (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] message_byte
  input  logic [0:0]  s_axis_tuser,   // [0] byte_valid
  input  logic        s_axis_tlast,   // end_of_message
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] digest_word
  output logic [2:0]  m_axis_tuser,   // [2:0] word_index
  output logic        m_axis_tlast    // last_word
);
  import sha_pkg::*;

  top_state_t st, st_next;
  comp_kind_t kind;
  logic [5:0]  fill, fill_new;
  logic [31:0] acc;
  logic [63:0] bit_count, total;
  logic        end_pending;
  logic [3:0]  pw;
  logic        pad_mark, len_here;
  logic [2:0]  idx;

  sha_ctl_t    ctl;
  logic        core_done;
  logic        b_we, b_re;
  logic [3:0]  b_waddr, b_raddr;
  logic [31:0] b_wdata, b_rdata, merged, pad_word, pad_data;
  logic        in_acc, out_acc;

  sha_ram #(.Width(32), .Depth(BlkWords)) u_blk_ram (
    .clk  (clk),
    .we   (b_we),
    .waddr(b_waddr),
    .wdata(b_wdata),
    .re   (b_re),
    .raddr(b_raddr),
    .rdata(b_rdata)
  );

  sha_core u_core (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .done     (core_done),
    .blk_re   (b_re),
    .blk_raddr(b_raddr),
    .blk_rdata(b_rdata),
    .dig_data (m_axis_tdata)
  );

  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign out_acc  = m_axis_tvalid && m_axis_tready;
  assign fill_new = s_axis_tuser[0] ? fill + 6'd1 : fill;
  assign total    = bit_count + {55'd0, fill, 3'b000};

  // Bytes go in big-endian within a word; lanes below the newest one stay zero.
  assign merged   = ((fill[1:0] == 2'd0) ? 32'd0 : acc)
                  | ({24'd0, s_axis_tdata} << {~fill[1:0], 3'b000});
  assign pad_word = ((fill[1:0] == 2'd0) ? 32'd0 : acc)
                  | ({24'd0, PadByte} << {~fill[1:0], 3'b000});

  always_comb begin
    if (pad_mark && (pw == fill[5:2])) begin
      pad_data = pad_word;
    end else if (len_here && (pw == LenWordHi)) begin
      pad_data = total[63:32];
    end else if (len_here && (pw == LenWordLo)) begin
      pad_data = total[31:0];
    end else begin
      pad_data = 32'd0;
    end
  end

  assign m_axis_tuser = idx;
  assign m_axis_tlast = (idx == 3'd7);

  always_comb begin
    st_next       = st;
    s_axis_tready = 1'b0;
    m_axis_tvalid = 1'b0;
    b_we          = 1'b0;
    b_waddr       = fill[5:2];
    b_wdata       = merged;
    ctl           = '0;
    ctl.dig_addr  = idx;
    case (st)
      T_IDLE: begin
        s_axis_tready = 1'b1;
        if (in_acc) begin
          if (s_axis_tuser[0]) begin
            b_we = 1'b1;
          end
          if (s_axis_tuser[0] && (fill == 6'd63)) begin
            ctl.start = 1'b1;
            st_next   = T_COMP;
          end else if (s_axis_tlast) begin
            st_next = T_PAD;
          end
        end
      end
      T_PAD: begin
        b_we    = 1'b1;
        b_waddr = pw;
        b_wdata = pad_data;
        if (pw == 4'd15) begin
          ctl.start = 1'b1;
          st_next   = T_COMP;
        end
      end
      T_COMP: begin
        if (core_done) begin
          unique case (kind)
            K_DATA:  st_next = end_pending ? T_PAD : T_IDLE;
            K_PADX:  st_next = T_PAD;
            K_FINAL: st_next = T_EMIT_RD;
            default: st_next = T_IDLE;
          endcase
        end
      end
      T_EMIT_RD: begin
        ctl.dig_re = 1'b1;
        st_next    = T_EMIT_OUT;
      end
      T_EMIT_OUT: begin
        m_axis_tvalid = 1'b1;
        if (m_axis_tready) begin
          if (idx == 3'd7) begin
            ctl.restart = 1'b1;
            st_next     = T_IDLE;
          end else begin
            st_next = T_EMIT_RD;
          end
        end
      end
      default: st_next = T_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st          <= T_IDLE;
      kind        <= K_DATA;
      fill        <= 6'd0;
      bit_count   <= 64'd0;
      end_pending <= 1'b0;
      pw          <= 4'd0;
      pad_mark    <= 1'b0;
      len_here    <= 1'b0;
      idx         <= 3'd0;
    end else begin
      st <= st_next;
      if ((st == T_IDLE) && in_acc) begin
        fill <= fill_new;
        if (s_axis_tuser[0] && (fill == 6'd63)) begin
          end_pending <= s_axis_tlast;
          kind        <= K_DATA;
        end else begin
          pw       <= fill_new[5:2];
          pad_mark <= 1'b1;
          len_here <= (fill_new < LenLimit);
        end
      end
      if (st == T_PAD) begin
        if (pw == 4'd15) begin
          kind <= len_here ? K_FINAL : K_PADX;
        end else begin
          pw <= pw + 4'd1;
        end
      end
      if ((st == T_COMP) && core_done) begin
        unique case (kind)
          K_DATA: begin
            bit_count <= bit_count + BlockBits;
            pw        <= 4'd0;
            pad_mark  <= 1'b1;
            len_here  <= 1'b1;
          end
          K_PADX: begin
            pw       <= 4'd0;
            pad_mark <= 1'b0;
            len_here <= 1'b1;
          end
          K_FINAL: idx <= 3'd0;
          default: idx <= 3'd0;
        endcase
      end
      if ((st == T_EMIT_OUT) && out_acc) begin
        if (idx == 3'd7) begin
          fill      <= 6'd0;
          bit_count <= 64'd0;
        end else begin
          idx <= idx + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if ((st == T_IDLE) && in_acc && s_axis_tuser[0]) begin
      acc <= merged;
    end
  end

  a_end_starts_work: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> !s_axis_tready)
    else $error("end of message did not start padding or compression");

  a_digest_restarts: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tready && m_axis_tlast)
      |=> ((fill == 6'd0) && (bit_count == 64'd0) && (st == T_IDLE)))
    else $error("message state not cleared after the last digest word");

  a_fill_held: assert property (@(posedge clk) disable iff (rst)
    (st == T_COMP) |=> $stable(fill))
    else $error("fill count changed during a compression");

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for sha256_message_hasher: streams message bytes and checks digests.
// A directed table with known digests comes first, then random messages scored by a SHA-256
// predictor written here. Depends only on the RTL top level.
module testbench;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_word_t;

  typedef struct packed {
    logic [7:0]   msg_byte;
    logic         has_byte;
    logic         eom;
    logic         known;
    logic [255:0] digest;
  } stim_row_t;

  typedef enum logic [1:0] {
    RX_FREE,
    RX_HALF,
    RX_SPARSE
  } rx_mode_t;

  localparam int unsigned CycleLimit  = 300000;
  localparam int unsigned LongHold    = 500;
  localparam int unsigned DrainCycles = 200;

  localparam logic [255:0] EmptyDigest =
    256'he3b0c442_98fc1c14_9afbf4c8_996fb924_27ae41e4_649b934c_a495991b_7852b855;
  localparam logic [255:0] AbcDigest =
    256'hba7816bf_8f01cfea_414140de_5dae2223_b00361a3_96177a9c_b410ff61_f20015ad;

  localparam stim_row_t DirRows [14] = '{
    '{8'h00, 1'b0, 1'b1, 1'b1, EmptyDigest},  // empty message straight out of reset
    '{8'h61, 1'b1, 1'b0, 1'b0, 256'h0},
    '{8'hFF, 1'b0, 1'b0, 1'b0, 256'h0},       // empty request in mid-message
    '{8'h62, 1'b1, 1'b0, 1'b0, 256'h0},
    '{8'h63, 1'b1, 1'b1, 1'b1, AbcDigest},
    '{8'h00, 1'b0, 1'b1, 1'b1, EmptyDigest},  // hash words must be back at their start
    '{8'h00, 1'b1, 1'b0, 1'b0, 256'h0},
    '{8'hFF, 1'b1, 1'b0, 1'b0, 256'h0},
    '{8'h80, 1'b1, 1'b1, 1'b0, 256'h0},
    '{8'hFF, 1'b1, 1'b1, 1'b0, 256'h0},
    '{8'h00, 1'b0, 1'b0, 1'b0, 256'h0},
    '{8'h5A, 1'b1, 1'b0, 1'b0, 256'h0},
    '{8'hA5, 1'b1, 1'b0, 1'b0, 256'h0},
    '{8'h3C, 1'b0, 1'b1, 1'b0, 256'h0}        // end without a byte, junk on the data lines
  };

  localparam logic [31:0] RoundConst [64] = '{
    32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5, 32'h3956C25B,
    32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5, 32'hD807AA98, 32'h12835B01,
    32'h243185BE, 32'h550C7DC3, 32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7,
    32'hC19BF174, 32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
    32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA, 32'h983E5152,
    32'hA831C66D, 32'hB00327C8, 32'hBF597FC7, 32'hC6E00BF3, 32'hD5A79147,
    32'h06CA6351, 32'h14292967, 32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC,
    32'h53380D13, 32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
    32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3, 32'hD192E819,
    32'hD6990624, 32'hF40E3585, 32'h106AA070, 32'h19A4C116, 32'h1E376C08,
    32'h2748774C, 32'h34B0BCB5, 32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F,
    32'h682E6FF3, 32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
    32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
  };

  localparam logic [31:0] StartHash [8] = '{
    32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
    32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] message_byte
  logic [0:0]  s_axis_tuser = 1'b0;    // [0] byte_valid
  logic        s_axis_tlast = 1'b0;    // end_of_message
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;           // [31:0] digest_word
  logic [2:0]  m_axis_tuser;           // [2:0] word_index
  logic        m_axis_tlast;           // last_word

  sha256_message_hasher uut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  always #2 clk = ~clk;

  // Hash predictor state.
  logic [7:0]  blk_bytes [64];
  logic [31:0] hash_st [8];
  logic [63:0] msg_bits;
  int unsigned blk_fill;

  digest_word_t expected_words [$];

  int unsigned error_count   = 0;
  int unsigned cycle_count   = 0;
  int unsigned burst_left    = 0;
  int unsigned hold_requests = 0;
  int unsigned hold_served   = 0;
  int unsigned hold_left     = 0;
  int unsigned rx_phase      = 0;
  rx_mode_t    rx_mode       = RX_FREE;

  function automatic logic [31:0] rotr(input logic [31:0] v, input int unsigned n);
    return (v >> n) | (v << (32 - n));
  endfunction

  function automatic void start_message_state();
    for (int k = 0; k < 8; k++) hash_st[k] = StartHash[k];
    msg_bits = 64'd0;
    blk_fill = 0;
  endfunction

  function automatic void compress_block();
    logic [31:0] w [64];
    logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
    for (int t = 0; t < 16; t++)
      w[t] = {blk_bytes[4*t], blk_bytes[4*t+1], blk_bytes[4*t+2], blk_bytes[4*t+3]};
    for (int t = 16; t < 64; t++) begin
      s0 = rotr(w[t-15], 7) ^ rotr(w[t-15], 18) ^ (w[t-15] >> 3);
      s1 = rotr(w[t-2], 17) ^ rotr(w[t-2], 19) ^ (w[t-2] >> 10);
      w[t] = s1 + w[t-7] + s0 + w[t-16];
    end
    a = hash_st[0]; b = hash_st[1]; c = hash_st[2]; d = hash_st[3];
    e = hash_st[4]; f = hash_st[5]; g = hash_st[6]; h = hash_st[7];
    for (int t = 0; t < 64; t++) begin
      t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
           + RoundConst[t] + w[t];
      t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e; e = d + t1;
      d = c; c = b; b = a; a = t1 + t2;
    end
    hash_st[0] += a; hash_st[1] += b; hash_st[2] += c; hash_st[3] += d;
    hash_st[4] += e; hash_st[5] += f; hash_st[6] += g; hash_st[7] += h;
  endfunction

  // Advances the predictor by one request; returns 1 with the digest when the message ends.
  function automatic bit predict_digest(input logic [7:0] msg_byte, input logic has_byte,
                                        input logic eom, output logic [255:0] digest);
    logic [63:0] total;
    int unsigned i;
    digest = '0;
    if (has_byte) begin
      blk_bytes[blk_fill] = msg_byte;
      blk_fill++;
      if (blk_fill == 64) begin
        compress_block();
        msg_bits += 64'd512;
        blk_fill = 0;
      end
    end
    if (!eom) return 1'b0;
    total = msg_bits + 64'(blk_fill) * 64'd8;
    i = blk_fill;
    blk_bytes[i] = 8'h80;
    i++;
    // The length no longer fits: pad out this block and put the length in a fresh one.
    if (i > 56) begin
      while (i < 64) begin
        blk_bytes[i] = 8'h00;
        i++;
      end
      compress_block();
      i = 0;
    end
    while (i < 56) begin
      blk_bytes[i] = 8'h00;
      i++;
    end
    for (int k = 0; k < 8; k++) blk_bytes[56+k] = total[63-8*k -: 8];
    compress_block();
    for (int k = 0; k < 8; k++) digest[255-32*k -: 32] = hash_st[k];
    start_message_state();
    return 1'b1;
  endfunction

  task automatic flag_error(input string msg);
    $display("ERROR cycle %0d: %s", cycle_count, msg);
    error_count++;
  endtask

  // Offers one request in bursts with random gaps, then feeds the predictor once it is taken.
  task automatic send_item(input logic [7:0] msg_byte, input logic has_byte, input logic eom,
                           input logic known, input logic [255:0] known_digest);
    logic [255:0] digest;
    int unsigned  gap;
    digest_word_t dw;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? 150 : $urandom_range(1, 12);
      gap = $urandom_range(1, 8);
      @(negedge clk);
      s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    burst_left--;
    @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= msg_byte;
    s_axis_tuser  <= has_byte;
    s_axis_tlast  <= eom;
    do @(posedge clk); while (!s_axis_tready);
    if (predict_digest(msg_byte, has_byte, eom, digest)) begin
      if (known) digest = known_digest;
      for (int k = 0; k < 8; k++) begin
        dw.word  = digest[255-32*k -: 32];
        dw.index = 3'(k);
        dw.last  = (k == 7);
        expected_words.push_back(dw);
      end
    end
  endtask

  task automatic sender_idle();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
  endtask

  task automatic wait_drained();
    while (expected_words.size() != 0) @(posedge clk);
  endtask

  // Random bytes with an occasional empty request mixed in.
  task automatic send_message(input int unsigned len, input bit eom_on_byte);
    for (int unsigned k = 0; k < len; k++) begin
      if ($urandom_range(0, 9) == 0) send_item(8'($urandom), 1'b0, 1'b0, 1'b0, '0);
      send_item(8'($urandom), 1'b1, eom_on_byte && (k == len - 1), 1'b0, '0);
    end
    if (!eom_on_byte || len == 0) send_item(8'($urandom), 1'b0, 1'b1, 1'b0, '0);
  endtask

  always @(negedge clk) begin
    rx_phase <= rx_phase + 1;
    if (rx_phase % 48 == 0) rx_mode <= rx_mode_t'($urandom_range(0, 2));
    if (hold_served != hold_requests) begin
      hold_served   <= hold_requests;
      hold_left     <= LongHold;
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      case (rx_mode)
        RX_FREE:   m_axis_tready <= 1'b1;
        RX_HALF:   m_axis_tready <= 1'($urandom_range(0, 1));
        default:   m_axis_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  always @(posedge clk) begin : check_digest
    digest_word_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_words.size() == 0) begin
        flag_error($sformatf("unexpected digest word %h index %0d", m_axis_tdata,
                             m_axis_tuser));
      end else begin
        want = expected_words.pop_front();
        if (m_axis_tdata !== want.word)
          flag_error($sformatf("index %0d: digest_word %h, want %h", want.index,
                               m_axis_tdata, want.word));
        if (m_axis_tuser !== want.index)
          flag_error($sformatf("word_index %0d, want %0d", m_axis_tuser, want.index));
        if (m_axis_tlast !== want.last)
          flag_error($sformatf("index %0d: last_word %b, want %b", want.index,
                               m_axis_tlast, want.last));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned msgs;
    int unsigned len;
    for (int k = 0; k < 64; k++) blk_bytes[k] = 8'h00;
    start_message_state();
    repeat (4) @(negedge clk);
    rst <= 1'b0;

    foreach (DirRows[r])
      send_item(DirRows[r].msg_byte, DirRows[r].has_byte, DirRows[r].eom, DirRows[r].known,
                DirRows[r].digest);
    sender_idle();
    wait_drained();

    // The receiver goes quiet for a long stretch while the next messages are offered.
    @(posedge clk);
    hold_requests++;
    send_message(3, 1'b1);
    send_message(56, 1'b1);   // 0x80 lands past byte 55, so the length needs a second block
    send_message(64, 1'b1);   // the end request itself completes a block
    msgs = 3;
    while (msgs < 6) begin
      len = $urandom_range(0, 8);
      send_message(len, 1'($urandom_range(0, 1)));
      msgs++;
    end
    sender_idle();
    wait_drained();
    repeat (DrainCycles) @(posedge clk);

    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/sha_pkg.sv
rtl/sha_ram.sv
rtl/sha_core.sv
rtl/sha256_message_hasher.sv
tb/testbench.sv
